// ===== rtl/core/wavhp_pkg.sv =====
package wavhp_pkg;

  // Result codes
  typedef enum logic [1:0] {
    KIND_ACCEPT = 2'd0,
    KIND_REJECT = 2'd1,
    KIND_SAMPLE = 2'd2
  } kind_t;

  // fmt chunk format tags
  localparam logic [15:0] TAG_PCM        = 16'h0001;
  localparam logic [15:0] TAG_EXTENSIBLE = 16'hFFFE;

  // One result item plus its valid flag, parser -> output stage
  typedef struct packed {
    logic               valid;
    kind_t              kind;
    logic signed [15:0] sample;
    logic [15:0]        channel_count;
    logic [31:0]        sample_rate;
    logic [30:0]        total_samples;
    logic               last;
  } res_t;

endpackage

// ===== rtl/core/wavhp_ifs.sv =====
interface wavhp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;
  logic       restart;
  logic       stream_end;

  modport source (output valid, output byte_in, output restart, output stream_end,
                  input ready);
  modport sink   (input valid, input byte_in, input restart, input stream_end,
                  output ready);
endinterface

interface wavhp_res_if;
  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic signed [15:0] sample;
  logic [15:0]        channel_count;
  logic [31:0]        sample_rate;
  logic [30:0]        total_samples;
  logic               last;

  modport source (output valid, output kind, output sample, output channel_count,
                  output sample_rate, output total_samples, output last,
                  input ready);
  modport sink   (input valid, input kind, input sample, input channel_count,
                  input sample_rate, input total_samples, input last,
                  output ready);
endinterface

// ===== rtl/core/wavhp_parse.sv =====
module wavhp_parse (
  input  logic              clk,
  input  logic              rst,
  input  logic              take,
  input  logic [7:0]        byte_in,
  input  logic              restart,
  input  logic              stream_end,
  output wavhp_pkg::res_t   res
);

  typedef enum logic [2:0] {
    PH_MAIN,
    PH_EXTLEN,
    PH_EXTSKIP,
    PH_FACTHDR,
    PH_FACTSKIP,
    PH_DATAHDR,
    PH_SAMPLES,
    PH_DONE
  } phase_t;

  typedef struct packed {
    phase_t      phase;
    logic [5:0]  pos;
    logic [31:0] skip;
    logic [31:0] fmt_len;
    logic [15:0] fmt_code;
    logic [15:0] chans;
    logic [31:0] rate;
    logic [15:0] bits;
    logic [31:0] payload;
    logic        id_ok;
    logic        fact_ok;
    logic [30:0] left;
    logic [7:0]  hold;
  } pstate_t;

  // chunk ids, byte 0 in the low lane
  localparam logic [31:0] ID_RIFF = 32'h4646_4952;
  localparam logic [31:0] ID_WAVE = 32'h4556_4157;
  localparam logic [31:0] ID_FMT  = 32'h2074_6D66;
  localparam logic [31:0] ID_DATA = 32'h6174_6164;
  localparam logic [31:0] ID_FACT = 32'h7463_6166;

  localparam logic [31:0] FMT_LEN_PCM    = 32'd16;

  localparam pstate_t PS_RESET = '{
    phase: PH_MAIN, pos: '0, skip: '0, fmt_len: '0, fmt_code: '0, chans: '0,
    rate: '0, bits: '0, payload: '0, id_ok: 1'b1, fact_ok: 1'b1, left: '0,
    hold: '0
  };

  pstate_t          st;
  pstate_t          st_next;
  pstate_t          cur;
  logic             emit;
  logic             hdr;
  logic             go_fmt;
  wavhp_pkg::kind_t rkind;
  logic [15:0]      smp;
  logic             rlast;

  always_comb begin
    cur     = restart ? PS_RESET : st;
    st_next = cur;
    emit    = 1'b0;
    hdr     = 1'b0;
    go_fmt  = 1'b0;
    rkind   = wavhp_pkg::KIND_ACCEPT;
    smp     = '0;
    rlast   = 1'b0;

    unique case (cur.phase)
      PH_MAIN: begin
        if (cur.pos < 6'd4) begin
          if (byte_in != ID_RIFF[8*cur.pos[1:0] +: 8]) st_next.id_ok = 1'b0;
        end else if (cur.pos >= 6'd8 && cur.pos < 6'd12) begin
          if (byte_in != ID_WAVE[8*cur.pos[1:0] +: 8]) st_next.id_ok = 1'b0;
        end else if (cur.pos >= 6'd12 && cur.pos < 6'd16) begin
          if (byte_in != ID_FMT[8*cur.pos[1:0] +: 8]) st_next.id_ok = 1'b0;
        end else if (cur.pos >= 6'd16 && cur.pos < 6'd20) begin
          st_next.fmt_len[8*cur.pos[1:0] +: 8] = cur.fmt_len[8*cur.pos[1:0] +: 8] | byte_in;
        end else if (cur.pos >= 6'd20 && cur.pos < 6'd22) begin
          st_next.fmt_code[8*cur.pos[0] +: 8] = cur.fmt_code[8*cur.pos[0] +: 8] | byte_in;
        end else if (cur.pos >= 6'd22 && cur.pos < 6'd24) begin
          st_next.chans[8*cur.pos[0] +: 8] = cur.chans[8*cur.pos[0] +: 8] | byte_in;
        end else if (cur.pos >= 6'd24 && cur.pos < 6'd28) begin
          st_next.rate[8*cur.pos[1:0] +: 8] = cur.rate[8*cur.pos[1:0] +: 8] | byte_in;
        end else if (cur.pos >= 6'd34 && cur.pos < 6'd36) begin
          st_next.bits[8*cur.pos[0] +: 8] = cur.bits[8*cur.pos[0] +: 8] | byte_in;
        end
        if (cur.pos >= 6'd35) begin
          if (st_next.fmt_len < FMT_LEN_PCM) begin
            emit          = 1'b1;
            rkind         = wavhp_pkg::KIND_REJECT;
            st_next.phase = PH_DONE;
          end else if (st_next.fmt_len != FMT_LEN_PCM) begin
            st_next.phase = PH_EXTLEN;
            st_next.pos   = '0;
          end else begin
            go_fmt = 1'b1;
          end
        end else begin
          st_next.pos = cur.pos + 6'd1;
        end
      end
      PH_EXTLEN: begin
        if (cur.pos == 6'd0) begin
          st_next.hold = byte_in;
          st_next.pos  = 6'd1;
        end else if (byte_in[7]) begin
          // negative extension length
          emit          = 1'b1;
          rkind         = wavhp_pkg::KIND_REJECT;
          st_next.phase = PH_DONE;
        end else begin
          st_next.skip = {16'h0000, byte_in, cur.hold};
          if (st_next.skip == 32'd0) go_fmt = 1'b1;
          else st_next.phase = PH_EXTSKIP;
        end
      end
      PH_EXTSKIP: begin
        st_next.skip = cur.skip - 32'd1;
        if (st_next.skip == 32'd0) go_fmt = 1'b1;
      end
      PH_FACTHDR: begin
        if (cur.pos < 6'd4) begin
          if (byte_in != ID_FACT[8*cur.pos[1:0] +: 8]) st_next.fact_ok = 1'b0;
        end else begin
          st_next.skip[8*cur.pos[1:0] +: 8] = cur.skip[8*cur.pos[1:0] +: 8] | byte_in;
        end
        if (cur.pos >= 6'd7) begin
          if (!st_next.fact_ok) begin
            emit          = 1'b1;
            rkind         = wavhp_pkg::KIND_REJECT;
            st_next.phase = PH_DONE;
          end else begin
            st_next.pos   = '0;
            st_next.phase = (st_next.skip == 32'd0) ? PH_DATAHDR : PH_FACTSKIP;
          end
        end else begin
          if (cur.pos == 6'd3) st_next.skip = '0;
          st_next.pos = cur.pos + 6'd1;
        end
      end
      PH_FACTSKIP: begin
        st_next.skip = cur.skip - 32'd1;
        if (st_next.skip == 32'd0) begin
          st_next.phase = PH_DATAHDR;
          st_next.pos   = '0;
        end
      end
      PH_DATAHDR: begin
        if (cur.pos < 6'd4) begin
          if (byte_in != ID_DATA[8*cur.pos[1:0] +: 8]) st_next.id_ok = 1'b0;
        end else begin
          st_next.payload[8*cur.pos[1:0] +: 8] =
            cur.payload[8*cur.pos[1:0] +: 8] | byte_in;
        end
        if (cur.pos < 6'd7) begin
          st_next.pos = cur.pos + 6'd1;
        end else if (!st_next.id_ok || st_next.bits[15:3] != 13'd2 ||
                     st_next.chans == 16'd0 || st_next.payload[0] ||
                     st_next.payload[31:1] == 31'd0 ||
                     (st_next.fmt_code != wavhp_pkg::TAG_PCM &&
                      st_next.fmt_code != wavhp_pkg::TAG_EXTENSIBLE)) begin
          emit          = 1'b1;
          rkind         = wavhp_pkg::KIND_REJECT;
          st_next.phase = PH_DONE;
        end else begin
          st_next.left  = st_next.payload[31:1];
          st_next.phase = PH_SAMPLES;
          st_next.pos   = '0;
          emit          = 1'b1;
          hdr           = 1'b1;
          rkind         = wavhp_pkg::KIND_ACCEPT;
        end
      end
      PH_SAMPLES: begin
        if (cur.pos == 6'd0) begin
          st_next.hold = byte_in;
          st_next.pos  = 6'd1;
        end else begin
          st_next.pos  = '0;
          st_next.left = cur.left - 31'd1;
          if (st_next.left == 31'd0) st_next.phase = PH_DONE;
          emit  = 1'b1;
          hdr   = 1'b1;
          rkind = wavhp_pkg::KIND_SAMPLE;
          smp   = {byte_in, cur.hold};
          rlast = (st_next.left == 31'd0);
        end
      end
      PH_DONE: begin
      end
    endcase

    // fmt chunk finished: fact chunk for the extensible tag, else data
    if (go_fmt) begin
      st_next.pos = '0;
      if (st_next.fmt_code == wavhp_pkg::TAG_EXTENSIBLE) begin
        st_next.phase   = PH_FACTHDR;
        st_next.fact_ok = 1'b1;
      end else begin
        st_next.phase = PH_DATAHDR;
      end
    end

    // truncated before the verdict rejects; any stream end closes the file
    if (stream_end) begin
      if (!emit && st_next.phase <= PH_DATAHDR) begin
        emit  = 1'b1;
        hdr   = 1'b0;
        rkind = wavhp_pkg::KIND_REJECT;
      end
      st_next.phase = PH_DONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= PS_RESET;
    end else if (take) begin
      st <= st_next;
    end
  end

  assign res.valid         = take && emit;
  assign res.kind          = rkind;
  assign res.sample        = smp;
  assign res.channel_count = hdr ? st_next.chans : 16'd0;
  assign res.sample_rate   = hdr ? st_next.rate : 32'd0;
  assign res.total_samples = hdr ? st_next.payload[31:1] : 31'd0;
  assign res.last          = rlast;

  a_done_silent: assert property (@(posedge clk) disable iff (rst)
    (take && !restart && st.phase == PH_DONE) |-> !res.valid)
    else $error("result produced after verdict");

  a_sample_phase: assert property (@(posedge clk) disable iff (rst)
    (res.valid && res.kind == wavhp_pkg::KIND_SAMPLE) |-> (cur.phase == PH_SAMPLES))
    else $error("sample outside payload");

  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (res.valid && res.last) |=> (st.phase == PH_DONE))
    else $error("last sample did not close the file");

endmodule

// ===== rtl/core/wav_header_parser_pcm16.sv =====
// WAV header parser with 16-bit PCM sample extraction.
// Results are registered: into the output register, or the skid entry on a stall.
// Throughput: one byte per cycle while ready; the parse logic decodes each in one step.
// A stalled output keeps taking bytes until the two-entry output stage fills.
// Reset (rst, synchronous): parser back to the main header, output stage empty.
module wav_header_parser_pcm16 (
  input  logic        clk,
  input  logic        rst,
  wavhp_byte_if.sink  byte_ch,
  wavhp_res_if.source result_ch
);

  // parse result for the byte transferred this cycle
  wavhp_pkg::res_t res;
  // output register and skid entry
  wavhp_pkg::res_t outq;
  wavhp_pkg::res_t skid;
  logic            out_valid;
  logic            skid_valid;
  logic            take;

  // bytes keep flowing until the skid entry is occupied
  assign byte_ch.ready = !skid_valid;
  assign take          = byte_ch.valid && byte_ch.ready;

  wavhp_parse u_parse (
    .clk        (clk),
    .rst        (rst),
    .take       (take),
    .byte_in    (byte_ch.byte_in),
    .restart    (byte_ch.restart),
    .stream_end (byte_ch.stream_end),
    .res        (res)
  );

  // Output stage control: the skid entry fills only when the output register
  // is stalled, and drains into it on the next transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || result_ch.ready) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= res.valid;
      end
    end else if (res.valid) begin
      skid_valid <= 1'b1;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    if (!out_valid || result_ch.ready) begin
      outq <= skid_valid ? skid : res;
    end else if (res.valid && !skid_valid) begin
      skid <= res;
    end
  end

  assign result_ch.valid         = out_valid;
  assign result_ch.kind          = outq.kind;
  assign result_ch.sample        = outq.sample;
  assign result_ch.channel_count = outq.channel_count;
  assign result_ch.sample_rate   = outq.sample_rate;
  assign result_ch.total_samples = outq.total_samples;
  assign result_ch.last          = outq.last;

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry held with empty output register");

  a_skid_on_stall: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_valid) |-> $past(out_valid && !result_ch.ready && res.valid))
    else $error("skid entry filled without a stall");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !result_ch.ready) |=> (out_valid && $stable(outq)))
    else $error("stalled result changed");

endmodule

// ===== tb/tb_wav_header_parser_pcm16.sv =====
module tb_wav_header_parser_pcm16;

  // Chunk ids as they appear in the stream, first byte in the top octet
  localparam logic [31:0] ID_RIFF = 32'h52494646;
  localparam logic [31:0] ID_WAVE = 32'h57415645;
  localparam logic [31:0] ID_FMT  = 32'h666D7420;
  localparam logic [31:0] ID_DATA = 32'h64617461;
  localparam logic [31:0] ID_FACT = 32'h66616374;

  localparam logic [31:0] FMT_BASE_LEN   = 32'd16;

  localparam int QUIET_LIMIT  = 2000;  // cycles with no transfer on either side
  localparam int DRAIN_CYCLES = 16;
  localparam int RANDOM_BYTES = 550;
  localparam int TAIL_BYTES   = 100;

  // Parser stages, in stream order; the order matters for the truncation rule
  typedef enum logic [3:0] {
    ST_HEADER, ST_EXT_LEN, ST_EXT_SKIP, ST_FACT_HDR, ST_FACT_SKIP,
    ST_DATA_HDR, ST_SAMPLES, ST_DONE
  } parse_state_t;

  typedef struct {
    wavhp_pkg::kind_t   kind;
    logic signed [15:0] sample;
    logic [15:0]        chans;
    logic [31:0]        rate;
    logic [30:0]        total;
    logic               last;
  } wav_result_t;

  // Knobs for building one file
  typedef struct {
    logic [31:0] fmt_len;
    logic [15:0] tag;
    logic [15:0] chans;
    logic [31:0] rate;
    logic [15:0] bits;
    logic [15:0] ext_len;
    logic [31:0] fact_id;
    logic [31:0] fact_size;
    logic [31:0] payload;
  } wav_spec_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  wavhp_byte_if byte_ch ();
  wavhp_res_if  result_ch ();

  wav_header_parser_pcm16 u_top (
    .clk       (clk),
    .rst       (rst),
    .byte_ch   (byte_ch),
    .result_ch (result_ch)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Parser model: its own copy of the header fields and stage
  // ---------------------------------------------------------------------------
  parse_state_t pst;
  logic [5:0]   pos;
  logic [31:0]  skip_left;
  logic [31:0]  fmt_len_r;
  logic [15:0]  fmt_tag;
  logic [15:0]  chans_r;
  logic [31:0]  rate_r;
  logic [15:0]  bits_r;
  logic [31:0]  payload_r;
  bit           ids_good;
  bit           fact_good;
  logic [30:0]  samples_left;
  logic [7:0]   low_hold;

  wav_result_t expected_q[$];   // verdicts and samples still owed by the DUT
  logic [7:0]  file_bytes[$];   // file under construction

  bit idle_en = 1'b1;
  int errors = 0;
  int files_sent = 0;
  int parsed_bytes = 0;         // bytes the parser actually had to look at
  int n_accept = 0;
  int n_reject = 0;
  int n_sample = 0;

  function automatic logic [7:0] id_byte(logic [31:0] id, int k);
    return id[31-8*k -: 8];
  endfunction

  function void parser_clear();
    pst          = ST_HEADER;
    pos          = '0;
    skip_left    = '0;
    fmt_len_r    = '0;
    fmt_tag      = '0;
    chans_r      = '0;
    rate_r       = '0;
    bits_r       = '0;
    payload_r    = '0;
    ids_good     = 1'b1;
    fact_good    = 1'b1;
    samples_left = '0;
    low_hold     = '0;
  endfunction

  function automatic wav_result_t make_result(wavhp_pkg::kind_t k, logic [15:0] smp,
                                              bit hdr, bit lst);
    wav_result_t r;
    r.kind   = k;
    r.sample = smp;
    r.chans  = hdr ? chans_r : '0;
    r.rate   = hdr ? rate_r : '0;
    r.total  = hdr ? payload_r[31:1] : '0;
    r.last   = lst;
    return r;
  endfunction

  function automatic wav_result_t reject_now();
    pst = ST_DONE;
    return make_result(wavhp_pkg::KIND_REJECT, '0, 1'b0, 1'b0);
  endfunction

  // fmt chunk fully consumed: extensible format needs a fact chunk next
  function void fmt_done();
    pos = '0;
    if (fmt_tag == wavhp_pkg::TAG_EXTENSIBLE) begin
      pst       = ST_FACT_HDR;
      fact_good = 1'b1;
    end else begin
      pst = ST_DATA_HDR;
    end
  endfunction

  function automatic bit parse_byte(input logic [7:0] b, output wav_result_t r);
    int p;
    p = pos;
    r = make_result(wavhp_pkg::KIND_REJECT, '0, 1'b0, 1'b0);
    case (pst)
      ST_HEADER: begin
        if (p < 4) begin
          if (b != id_byte(ID_RIFF, p)) ids_good = 1'b0;
        end else if (p >= 8 && p < 12) begin
          if (b != id_byte(ID_WAVE, p - 8)) ids_good = 1'b0;
        end else if (p >= 12 && p < 16) begin
          if (b != id_byte(ID_FMT, p - 12)) ids_good = 1'b0;
        end else if (p >= 16 && p < 20) begin
          fmt_len_r |= 32'(b) << (8 * (p - 16));
        end else if (p >= 20 && p < 22) begin
          fmt_tag |= 16'(b) << (8 * (p - 20));
        end else if (p >= 22 && p < 24) begin
          chans_r |= 16'(b) << (8 * (p - 22));
        end else if (p >= 24 && p < 28) begin
          rate_r |= 32'(b) << (8 * (p - 24));
        end else if (p >= 34 && p < 36) begin
          bits_r |= 16'(b) << (8 * (p - 34));
        end
        if (p >= 35) begin
          // short fmt chunk is fatal; a longer one carries an extension
          if (fmt_len_r < FMT_BASE_LEN) begin
            r = reject_now();
            return 1'b1;
          end
          if (fmt_len_r != FMT_BASE_LEN) begin
            pst = ST_EXT_LEN;
            pos = '0;
          end else begin
            fmt_done();
          end
        end else begin
          pos = 6'(p + 1);
        end
        return 1'b0;
      end
      ST_EXT_LEN: begin
        if (p == 0) begin
          low_hold = b;
          pos      = 6'd1;
          return 1'b0;
        end
        // extension length is signed; negative is fatal
        if (b[7]) begin
          r = reject_now();
          return 1'b1;
        end
        skip_left = {16'h0, b, low_hold};
        if (skip_left == 0) fmt_done();
        else pst = ST_EXT_SKIP;
        return 1'b0;
      end
      ST_EXT_SKIP: begin
        skip_left--;
        if (skip_left == 0) fmt_done();
        return 1'b0;
      end
      ST_FACT_HDR: begin
        if (p < 4) begin
          if (b != id_byte(ID_FACT, p)) fact_good = 1'b0;
        end else begin
          skip_left |= 32'(b) << (8 * ((p - 4) & 3));
        end
        if (p >= 7) begin
          if (!fact_good) begin
            r = reject_now();
            return 1'b1;
          end
          pos = '0;
          pst = (skip_left == 0) ? ST_DATA_HDR : ST_FACT_SKIP;
        end else begin
          if (p == 3) skip_left = '0;
          pos = 6'(p + 1);
        end
        return 1'b0;
      end
      ST_FACT_SKIP: begin
        skip_left--;
        if (skip_left == 0) begin
          pst = ST_DATA_HDR;
          pos = '0;
        end
        return 1'b0;
      end
      ST_DATA_HDR: begin
        if (p < 4) begin
          if (b != id_byte(ID_DATA, p)) ids_good = 1'b0;
        end else begin
          payload_r |= 32'(b) << (8 * ((p - 4) & 3));
        end
        if (p < 7) begin
          pos = 6'(p + 1);
          return 1'b0;
        end
        // final verdict on the last data header byte
        if (!ids_good || (bits_r >> 3) != 16'd2 || chans_r == 0 || payload_r[0] ||
            payload_r[31:1] == 0 ||
            (fmt_tag != wavhp_pkg::TAG_PCM && fmt_tag != wavhp_pkg::TAG_EXTENSIBLE)) begin
          r = reject_now();
          return 1'b1;
        end
        samples_left = payload_r[31:1];
        pst          = ST_SAMPLES;
        pos          = '0;
        r            = make_result(wavhp_pkg::KIND_ACCEPT, '0, 1'b1, 1'b0);
        return 1'b1;
      end
      ST_SAMPLES: begin
        if (p == 0) begin
          low_hold = b;
          pos      = 6'd1;
          return 1'b0;
        end
        pos = '0;
        samples_left--;
        if (samples_left == 0) pst = ST_DONE;
        r = make_result(wavhp_pkg::KIND_SAMPLE, {b, low_hold}, 1'b1, samples_left == 0);
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  // Called once per byte transfer; queues whatever the DUT owes for it
  function void predict(logic [7:0] b, bit rs, bit se);
    wav_result_t r;
    bit got;
    if (rs) parser_clear();
    if (pst != ST_DONE) parsed_bytes++;
    got = parse_byte(b, r);
    if (se) begin
      // end of stream before the header verdict is a reject
      if (!got && pst <= ST_DATA_HDR) begin
        r   = reject_now();
        got = 1'b1;
      end
      pst = ST_DONE;
    end
    if (got) expected_q.push_back(r);
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: random back-pressure and in-order compare
  // ---------------------------------------------------------------------------
  logic sink_ready = 1'b0;
  int   stall_left = 0;

  assign result_ch.ready = sink_ready;

  always @(posedge clk) begin
    if (stall_left > 0) stall_left--;
    else if (idle_en && $urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 11);
    sink_ready <= (stall_left == 0);
  end

  function void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0h, actual %0h", name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    wav_result_t e;
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (expected_q.size() == 0) begin
        $error("unexpected result transfer, kind %0d", result_ch.kind);
        errors++;
      end else begin
        e = expected_q.pop_front();
        check_field("kind", e.kind, result_ch.kind);
        check_field("sample", e.sample, result_ch.sample);
        check_field("channel_count", e.chans, result_ch.channel_count);
        check_field("sample_rate", e.rate, result_ch.sample_rate);
        check_field("total_samples", e.total, result_ch.total_samples);
        check_field("last", e.last, result_ch.last);
      end
      if (result_ch.kind == wavhp_pkg::KIND_ACCEPT) n_accept++;
      else if (result_ch.kind == wavhp_pkg::KIND_REJECT) n_reject++;
      else n_sample++;
    end
  end

  // Watchdog: a hung DUT stops all transfers
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if (rst || (byte_ch.valid && byte_ch.ready) || (result_ch.valid && result_ch.ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
               quiet_cycles, expected_q.size());
      $display("tb_wav_header_parser_pcm16 failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Byte source
  // ---------------------------------------------------------------------------
  // valid stays high between back-to-back bytes; it only drops for an idle burst
  task automatic send_byte(logic [7:0] b, bit rs, bit se);
    int gap;
    if (idle_en && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 11);
      byte_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    byte_ch.valid      <= 1'b1;
    byte_ch.byte_in    <= b;
    byte_ch.restart    <= rs;
    byte_ch.stream_end <= se;
    @(posedge clk);
    while (!byte_ch.ready) @(posedge clk);
    predict(b, rs, se);
  endtask

  // restart on byte 0; stream_end on the final byte if asked
  task automatic send_file(bit end_last);
    int n;
    n = file_bytes.size();
    files_sent++;
    for (int i = 0; i < n; i++)
      send_byte(file_bytes[i], i == 0, end_last && i == n - 1);
  endtask

  // ---------------------------------------------------------------------------
  // File construction
  // ---------------------------------------------------------------------------
  function automatic wav_spec_t plain_spec();
    wav_spec_t s;
    s.fmt_len   = FMT_BASE_LEN;
    s.tag       = wavhp_pkg::TAG_PCM;
    s.chans     = 16'd2;
    s.rate      = 32'd48000;
    s.bits      = 16'd16;
    s.ext_len   = '0;
    s.fact_id   = ID_FACT;
    s.fact_size = '0;
    s.payload   = 32'd8;
    return s;
  endfunction

  function void put_le(logic [31:0] v, int n);
    for (int k = 0; k < n; k++) file_bytes.push_back(v[8*k +: 8]);
  endfunction

  function void put_id(logic [31:0] id);
    for (int k = 0; k < 4; k++) file_bytes.push_back(id_byte(id, k));
  endfunction

  // skipped or payload bytes, capped so huge lengths stay cheap
  function void put_filler(logic [31:0] n, int cap);
    for (int i = 0; i < n && i < cap; i++) file_bytes.push_back(8'($urandom));
  endfunction

  function void build_file(wav_spec_t s, int cap);
    file_bytes.delete();
    put_id(ID_RIFF);
    put_le($urandom, 4);
    put_id(ID_WAVE);
    put_id(ID_FMT);
    put_le(s.fmt_len, 4);
    put_le(s.tag, 2);
    put_le(s.chans, 2);
    put_le(s.rate, 4);
    put_le($urandom, 4);
    put_le($urandom, 2);
    put_le(s.bits, 2);
    if (s.fmt_len > FMT_BASE_LEN) begin
      put_le(s.ext_len, 2);
      if (!s.ext_len[15]) put_filler(s.ext_len, cap);
    end
    if (s.tag == wavhp_pkg::TAG_EXTENSIBLE) begin
      put_id(s.fact_id);
      put_le(s.fact_size, 4);
      put_filler(s.fact_size, cap);
    end
    put_id(ID_DATA);
    put_le(s.payload, 4);
    put_filler(s.payload, cap);
  endfunction

  function void truncate_file(int len);
    file_bytes = file_bytes[0:len-1];
  endfunction

  // ---------------------------------------------------------------------------
  // Directed tests
  // ---------------------------------------------------------------------------
  // Plain PCM with the four sample extremes in the payload
  task automatic test_plain_pcm();
    wav_spec_t s;
    logic [7:0] extremes [8] = '{8'h00, 8'h80, 8'hFF, 8'h7F, 8'h00, 8'h00, 8'hFF, 8'hFF};
    int n;
    s = plain_spec();
    build_file(s, 64);
    n = file_bytes.size();
    for (int i = 0; i < 8; i++) file_bytes[n - 8 + i] = extremes[i];
    send_file(1'b1);
  endtask

  // Extension skip, fact chunk, both, and the longest legal extension
  task automatic test_extensions();
    wav_spec_t s;
    s = plain_spec();
    s.tag       = wavhp_pkg::TAG_EXTENSIBLE;
    s.fmt_len   = 32'd40;
    s.ext_len   = 16'd22;
    s.fact_size = 32'd4;
    s.payload   = 32'd6;
    s.chans     = 16'hFFFF;
    s.rate      = 32'hFFFF_FFFF;
    build_file(s, 64);
    send_file(1'b1);

    // extensible with zero-length extension and empty fact chunk
    s.fmt_len   = 32'd18;
    s.ext_len   = '0;
    s.fact_size = '0;
    s.payload   = 32'd4;
    build_file(s, 64);
    send_file(1'b1);

    // plain PCM that still carries an extension
    s = plain_spec();
    s.fmt_len = 32'hFFFF_FFFF;
    s.ext_len = 16'd3;
    s.chans   = 16'd1;
    s.rate    = '0;
    build_file(s, 64);
    send_file(1'b1);

    // longest extension; the stream ends while it is still being skipped
    s = plain_spec();
    s.fmt_len = 32'd18;
    s.ext_len = 16'h7FFF;
    s.payload = 32'd2;
    build_file(s, 8);
    send_file(1'b1);
  endtask

  // One fault per file; the last case is an odd-but-legal bit depth
  task automatic test_header_rejects();
    wav_spec_t s;
    for (int c = 0; c < 15; c++) begin
      s = plain_spec();
      case (c)
        0: s.fmt_len = 32'd14;
        1: begin s.fmt_len = 32'd18; s.ext_len = 16'h8000; end
        2: begin s.fmt_len = 32'd18; s.ext_len = 16'hFFFF; end
        3: begin s.tag = wavhp_pkg::TAG_EXTENSIBLE; s.fact_id = ID_FACT ^ 32'h1; end
        4: s.bits = 16'd8;
        5: s.bits = 16'd24;
        6: s.chans = '0;
        7: s.payload = 32'd7;
        8: s.payload = '0;
        9: s.tag = 16'd3;
        14: s.bits = 16'd23;
        default: ;
      endcase
      build_file(s, 16);
      // broken chunk ids
      case (c)
        10: file_bytes[0]  ^= 8'h01;
        11: file_bytes[11] ^= 8'h01;
        12: file_bytes[15] ^= 8'h01;
        13: file_bytes[39] ^= 8'h01;
        default: ;
      endcase
      send_file(1'b1);
    end
  endtask

  // Stream ends inside each header stage, and on the accept byte itself
  task automatic test_truncation();
    wav_spec_t s;
    int cuts [5] = '{1, 20, 36, 43, 44};
    s = plain_spec();
    s.payload = 32'd4;
    foreach (cuts[i]) begin
      build_file(s, 16);
      truncate_file(cuts[i]);
      send_file(1'b1);
    end
    // inside the extension skip
    s.fmt_len = 32'd18;
    s.ext_len = 16'd4;
    build_file(s, 16);
    truncate_file(40);
    send_file(1'b1);
    // inside the fact header
    s = plain_spec();
    s.tag = wavhp_pkg::TAG_EXTENSIBLE;
    build_file(s, 16);
    truncate_file(41);
    send_file(1'b1);
  endtask

  // Stream ends mid-payload: on a lone low byte, on a full sample, huge count
  task automatic test_payload_cut();
    wav_spec_t s;
    s = plain_spec();
    s.payload = 32'd10;
    build_file(s, 16);
    truncate_file(47);
    send_file(1'b1);
    build_file(s, 16);
    truncate_file(48);
    send_file(1'b1);
    s.payload = 32'hFFFF_FFFE;
    build_file(s, 8);
    send_file(1'b1);
  endtask

  // Bytes past the verdict and restart while samples are still pending
  task automatic test_after_verdict();
    wav_spec_t s;
    s = plain_spec();
    s.bits = 16'd8;
    build_file(s, 16);
    send_file(1'b0);
    repeat (6) send_byte(8'($urandom), 1'b0, 1'b0);
    s = plain_spec();
    s.payload = 32'd2;
    build_file(s, 16);
    send_file(1'b0);
    repeat (5) send_byte(8'($urandom), 1'b0, 1'b0);
    send_byte(8'($urandom), 1'b0, 1'b1);
    s.payload = 32'd20;
    build_file(s, 32);
    truncate_file(50);
    send_file(1'b0);
    s.payload = 32'd4;
    build_file(s, 16);
    send_file(1'b1);
  endtask

  // ---------------------------------------------------------------------------
  // Random files: mostly well formed with random fields, some corrupted or noise
  // ---------------------------------------------------------------------------
  task automatic random_file();
    wav_spec_t s;
    int sel;
    int cut;
    if ($urandom_range(0, 19) == 0) begin
      file_bytes.delete();
      repeat ($urandom_range(1, 60)) file_bytes.push_back(8'($urandom));
      send_file($urandom_range(0, 1));
      return;
    end
    s = plain_spec();
    sel = $urandom_range(0, 9);
    s.tag = (sel < 6) ? wavhp_pkg::TAG_PCM :
            (sel < 9) ? wavhp_pkg::TAG_EXTENSIBLE : 16'($urandom);
    sel = $urandom_range(0, 19);
    if (sel < 10) s.fmt_len = FMT_BASE_LEN;
    else if (sel < 18) s.fmt_len = 32'(17 + $urandom_range(0, 23));
    else if (sel == 18) s.fmt_len = $urandom;
    else s.fmt_len = 32'($urandom_range(0, 15));
    s.ext_len   = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 6));
    s.chans     = ($urandom_range(0, 9) == 0) ? 16'h0 : 16'($urandom);
    s.rate      = $urandom;
    s.bits      = ($urandom_range(0, 9) < 9) ? 16'd16 : 16'($urandom);
    s.fact_id   = ($urandom_range(0, 19) == 0) ? $urandom : ID_FACT;
    s.fact_size = ($urandom_range(0, 9) == 0) ? $urandom : 32'($urandom_range(0, 6));
    s.payload   = ($urandom_range(0, 7) == 0) ? $urandom : 32'(2 * $urandom_range(1, 12));
    build_file(s, 24);
    if ($urandom_range(0, 9) == 0)
      file_bytes[$urandom_range(0, 47)] = 8'($urandom);
    sel = $urandom_range(0, 19);
    if (sel < 10) begin
      send_file(1'b1);
    end else if (sel < 13) begin
      cut = $urandom_range(1, file_bytes.size());
      truncate_file(cut);
      send_file(1'b1);
    end else begin
      send_file(1'b0);
      repeat ($urandom_range(0, 3)) send_byte(8'($urandom), 1'b0, 1'b0);
    end
  endtask

  task automatic test_random_files(int n_bytes);
    int start;
    start = parsed_bytes;
    while (parsed_bytes - start < n_bytes) begin
      idle_en = ($urandom_range(0, 3) != 0);
      random_file();
    end
  endtask

  // Back-to-back traffic with no idling on either side
  task automatic test_quiet_tail(int n_bytes);
    int start;
    idle_en = 1'b0;
    start = parsed_bytes;
    while (parsed_bytes - start < n_bytes) random_file();
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    byte_ch.valid      <= 1'b0;
    byte_ch.byte_in    <= '0;
    byte_ch.restart    <= 1'b0;
    byte_ch.stream_end <= 1'b0;
    parser_clear();
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    test_plain_pcm();
    test_extensions();
    test_header_rejects();
    test_truncation();
    test_payload_cut();
    test_after_verdict();
    test_random_files(RANDOM_BYTES);
    test_quiet_tail(TAIL_BYTES);

    byte_ch.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("sent %0d files, %0d bytes reached the parser", files_sent, parsed_bytes);
    $display("checked %0d accepts, %0d rejects, %0d samples; %0d mismatches",
             n_accept, n_reject, n_sample, errors);
    if (errors == 0) begin
      $display("tb_wav_header_parser_pcm16 passed");
    end else begin
      $display("tb_wav_header_parser_pcm16 failed");
    end
    $finish;
  end

endmodule
